// ----- src/channel_blend_merge_unit_assert.svh -----
// Assertion macros for the channel blend/merge block.
`ifndef CHANNEL_BLEND_MERGE_UNIT_ASSERT_SVH
`define CHANNEL_BLEND_MERGE_UNIT_ASSERT_SVH

`ifndef SYNTH

`define CBM_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("channel_blend_merge_unit: same-cycle check failed");

`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("channel_blend_merge_unit: next-cycle check failed");

`else

`define CBM_ASSERT_HOLD(label, clk, rst_n, ante, cons)

`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/cbm_pkg.sv -----
package cbm_pkg;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int PIX_BITS  = 16;

    typedef enum logic [2:0] {
        CH_RED   = 3'd0,
        CH_GREEN = 3'd1,
        CH_BLUE  = 3'd2,
        CH_ALPHA = 3'd3,
        CH_LUMA  = 3'd4
    } t_chan;

    typedef enum logic [1:0] {
        TGT_RED   = 2'd0,
        TGT_GREEN = 2'd1,
        TGT_BLUE  = 2'd2,
        TGT_ALPHA = 2'd3
    } t_tgt;

    typedef enum logic [2:0] {
        OP_COPY     = 3'd0,
        OP_PLUS     = 3'd1,
        OP_MULTIPLY = 3'd2,
        OP_SCREEN   = 3'd3,
        OP_MAX      = 3'd4,
        OP_MIN      = 3'd5,
        OP_SUBTRACT = 3'd6,
        OP_OVERLAY  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        REG_A_CHANNEL = 3'd0,
        REG_B_CHANNEL = 3'd1,
        REG_BLEND_OP  = 3'd2,
        REG_TARGET    = 3'd3,
        REG_MIX       = 3'd4,
        REG_CLAMP     = 3'd5,
        REG_A_COUNT   = 3'd6,
        REG_B_COUNT   = 3'd7
    } t_reg_idx;

    localparam logic [12:0] ONE_Q12 = 13'd4096;

    localparam int LUMA_R = 871;
    localparam int LUMA_G = 2929;
    localparam int LUMA_B = 296;

    localparam logic [2:0]  RST_A_CHANNEL = 3'd0;
    localparam logic [2:0]  RST_B_CHANNEL = 3'd3;
    localparam logic [2:0]  RST_BLEND_OP  = 3'd4;
    localparam logic [1:0]  RST_TARGET    = 2'd3;
    localparam logic [12:0] RST_MIX       = 13'd4096;
    localparam logic        RST_CLAMP     = 1'b0;
    localparam logic [2:0]  RST_A_COUNT   = 3'd4;
    localparam logic [2:0]  RST_B_COUNT   = 3'd4;

    localparam logic [2:0]  MAX_COUNT     = 3'd4;

    typedef struct packed {
        t_chan       a_ch;
        t_chan       b_ch;
        t_op         op;
        logic        tgt_en;
        logic [1:0]  tgt_idx;
        logic [12:0] mix;
        logic        clamp;
        logic [2:0]  a_cnt;
        logic [2:0]  b_cnt;
    } t_cfg;

endpackage

// ----- src/channel_blend_merge_unit.sv -----
// Channel blend/merge unit: per pixel, samples one channel of an A and a B
// pixel, blends the two samples, mixes the result into one channel of B.
// Input channel: i_valid / o_stall with the A and B pixel fields and their
// inside flags. A transfer happens at an edge where i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall with the four output
// components, same transfer rule.
// Configuration: APB port, register i at byte address 4*i, pready tied
// high; to be written only while the pipeline is empty (user's duty,
// the block does not enforce it). Throughput: one pixel per clock while
// o_stall is low, through the six-stage pipeline (luma products, sample
// select, blend multiply, blend finish, mix multiply, mix finish).
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under an output stall; o_stall rises only once all six
// stages are full and i_stall is high.
// Reset (i_rst_n low, synchronous): all stages emptied, registers return
// to their defaults (A red, B alpha, max, target alpha, full mix, no clamp,
// four components on both sides).

`include "channel_blend_merge_unit_assert.svh"

module channel_blend_merge_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [15:0]             i_a_red,
    input  logic signed [15:0]             i_a_green,
    input  logic signed [15:0]             i_a_blue,
    input  logic signed [15:0]             i_a_alpha,
    input  logic                           i_a_inside,
    input  logic signed [15:0]             i_b_red,
    input  logic signed [15:0]             i_b_green,
    input  logic signed [15:0]             i_b_blue,
    input  logic signed [15:0]             i_b_alpha,
    input  logic                           i_b_inside,

    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [15:0]             o_out_red,
    output logic signed [15:0]             o_out_green,
    output logic signed [15:0]             o_out_blue,
    output logic signed [15:0]             o_out_alpha,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [cbm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [cbm_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    localparam int PB   = cbm_pkg::PIX_BITS;
    localparam int SW   = (SAMPLE_BITS > PB) ? SAMPLE_BITS : PB;
    localparam int EW   = SW + 2;
    localparam int WD   = 2 * SW + 6;
    localparam int LPW  = PB + 12;
    localparam int MW   = 15;
    localparam int NSTG = 6;

    localparam logic signed [WD-1:0]  SMAX_W = (WD'(1) <<< (SAMPLE_BITS - 1)) - WD'(1);
    localparam logic signed [WD-1:0]  SMIN_W = -SMAX_W - WD'(1);
    localparam logic signed [SW-1:0]  ONE_S  = SW'(cbm_pkg::ONE_Q12);
    localparam logic signed [SW-1:0]  HALF_S = SW'(cbm_pkg::ONE_Q12 >> 1);
    localparam logic signed [EW-1:0]  ONE_E  = EW'(cbm_pkg::ONE_Q12);
    localparam logic signed [WD-1:0]  ONE_W  = WD'(cbm_pkg::ONE_Q12);
    localparam logic signed [WD-1:0]  RND12  = WD'(cbm_pkg::ONE_Q12 >> 1);
    localparam logic signed [WD-1:0]  RND11  = WD'(cbm_pkg::ONE_Q12 >> 2);
    localparam logic signed [MW-1:0]  ONE_M  = MW'(cbm_pkg::ONE_Q12);
    localparam logic signed [LPW-1:0] LUMA_R_L = LPW'(cbm_pkg::LUMA_R);
    localparam logic signed [LPW-1:0] LUMA_G_L = LPW'(cbm_pkg::LUMA_G);
    localparam logic signed [LPW-1:0] LUMA_B_L = LPW'(cbm_pkg::LUMA_B);

    function automatic logic signed [SW-1:0] sat_s(input logic signed [WD-1:0] v);
        logic signed [SW-1:0] s;
        if (v > SMAX_W) begin
            s = SMAX_W[SW-1:0];
        end else if (v < SMIN_W) begin
            s = SMIN_W[SW-1:0];
        end else begin
            s = v[SW-1:0];
        end
        return s;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(
        input logic signed [PB-1:0] c0,
        input logic signed [PB-1:0] c1,
        input logic signed [PB-1:0] c2,
        input logic signed [PB-1:0] c3,
        input logic                 present,
        input logic [2:0]           cnt,
        input cbm_pkg::t_chan       ch,
        input logic signed [SW-1:0] luma
    );
        logic signed [SW-1:0] s;
        s = '0;
        if (present) begin
            if (cnt == 3'd1) begin
                s = SW'(c0);
            end else begin
                case (ch)
                    cbm_pkg::CH_RED:   s = SW'(c0);
                    cbm_pkg::CH_GREEN: s = SW'(c1);
                    cbm_pkg::CH_BLUE:  s = (cnt > 3'd2) ? SW'(c2) : '0;
                    cbm_pkg::CH_ALPHA: s = (cnt > 3'd3) ? SW'(c3) : ONE_S;
                    default:           s = luma;
                endcase
            end
        end
        return s;
    endfunction

    cbm_pkg::t_cfg cfg;

    cbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // stage 1: capture pixels, luminance products
    logic signed [PB-1:0]  r_s1_apx [4];
    logic signed [PB-1:0]  r_s1_bpx [4];
    logic                  r_s1_ain;
    logic                  r_s1_bin;
    logic signed [LPW-1:0] r_s1_a_lr, r_s1_a_lg, r_s1_a_lb;
    logic signed [LPW-1:0] r_s1_b_lr, r_s1_b_lg, r_s1_b_lb;
    logic signed [PB-1:0]  n_a_lblue, n_b_lblue;

    assign n_a_lblue = (cfg.a_cnt > 3'd2) ? i_a_blue : i_a_red;
    assign n_b_lblue = (cfg.b_cnt > 3'd2) ? i_b_blue : i_b_red;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1_apx[0] <= i_a_red;
            r_s1_apx[1] <= i_a_green;
            r_s1_apx[2] <= i_a_blue;
            r_s1_apx[3] <= i_a_alpha;
            r_s1_bpx[0] <= i_b_red;
            r_s1_bpx[1] <= i_b_green;
            r_s1_bpx[2] <= i_b_blue;
            r_s1_bpx[3] <= i_b_alpha;
            r_s1_ain    <= i_a_inside;
            r_s1_bin    <= i_b_inside;
            r_s1_a_lr   <= LPW'(i_a_red) * LUMA_R_L;
            r_s1_a_lg   <= LPW'(i_a_green) * LUMA_G_L;
            r_s1_a_lb   <= LPW'(n_a_lblue) * LUMA_B_L;
            r_s1_b_lr   <= LPW'(i_b_red) * LUMA_R_L;
            r_s1_b_lg   <= LPW'(i_b_green) * LUMA_G_L;
            r_s1_b_lb   <= LPW'(n_b_lblue) * LUMA_B_L;
        end
    end

    // stage 2: luminance sum, sample select, base pixel
    logic signed [SW-1:0] r_s2_sa, r_s2_sb;
    logic signed [PB-1:0] r_s2_base [4];
    logic signed [SW-1:0] n_a_luma, n_b_luma;

    assign n_a_luma = sat_s((WD'(r_s1_a_lr) + WD'(r_s1_a_lg) + WD'(r_s1_a_lb)
                             + RND12) >>> 12);
    assign n_b_luma = sat_s((WD'(r_s1_b_lr) + WD'(r_s1_b_lg) + WD'(r_s1_b_lb)
                             + RND12) >>> 12);

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s2_sa <= pick_sample(r_s1_apx[0], r_s1_apx[1], r_s1_apx[2], r_s1_apx[3],
                                   r_s1_ain, cfg.a_cnt, cfg.a_ch, n_a_luma);
            r_s2_sb <= pick_sample(r_s1_bpx[0], r_s1_bpx[1], r_s1_bpx[2], r_s1_bpx[3],
                                   r_s1_bin, cfg.b_cnt, cfg.b_ch, n_b_luma);
            for (int i = 0; i < 4; i++) begin
                r_s2_base[i] <= (r_s1_bin && (3'(i) < cfg.b_cnt)) ? r_s1_bpx[i] : '0;
            end
        end
    end

    // stage 3: blend multiply, on the samples or their complements
    logic signed [SW-1:0]     r_s3_sa, r_s3_sb;
    logic signed [2*EW-1:0]   r_s3_prod;
    logic                     r_s3_inv;
    logic signed [PB-1:0]     r_s3_base [4];
    logic                     n_inv;
    logic signed [EW-1:0]     n_x, n_y;

    always_comb begin
        n_inv = (cfg.op == cbm_pkg::OP_SCREEN) ||
                ((cfg.op == cbm_pkg::OP_OVERLAY) && (r_s2_sb > HALF_S));
        n_x   = n_inv ? (ONE_E - EW'(r_s2_sa)) : EW'(r_s2_sa);
        n_y   = n_inv ? (ONE_E - EW'(r_s2_sb)) : EW'(r_s2_sb);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s3_sa   <= r_s2_sa;
            r_s3_sb   <= r_s2_sb;
            r_s3_prod <= n_x * n_y;
            r_s3_inv  <= n_inv;
            r_s3_base <= r_s2_base;
        end
    end

    // stage 4: finish blend
    logic signed [SW-1:0] r_s4_r;
    logic signed [PB-1:0] r_s4_base [4];
    logic signed [WD-1:0] n_pw, n_sh, n_q;
    logic signed [SW-1:0] n_blend;

    always_comb begin
        n_pw = WD'(r_s3_prod);
        n_sh = (cfg.op == cbm_pkg::OP_OVERLAY) ? ((n_pw + RND11) >>> 11)
                                               : ((n_pw + RND12) >>> 12);
        n_q  = r_s3_inv ? (ONE_W - n_sh) : n_sh;
        case (cfg.op)
            cbm_pkg::OP_COPY:     n_blend = r_s3_sa;
            cbm_pkg::OP_PLUS:     n_blend = sat_s(WD'(r_s3_sb) + WD'(r_s3_sa));
            cbm_pkg::OP_MAX:      n_blend = (r_s3_sb > r_s3_sa) ? r_s3_sb : r_s3_sa;
            cbm_pkg::OP_MIN:      n_blend = (r_s3_sb < r_s3_sa) ? r_s3_sb : r_s3_sa;
            cbm_pkg::OP_SUBTRACT: n_blend = sat_s(WD'(r_s3_sb) - WD'(r_s3_sa));
            default:              n_blend = sat_s(n_q);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s4_r    <= n_blend;
            r_s4_base <= r_s3_base;
        end
    end

    // stage 5: mix multiplies
    logic signed [PB+MW-1:0] r_s5_po;
    logic signed [SW+MW-1:0] r_s5_pr;
    logic signed [PB-1:0]    r_s5_base [4];
    logic signed [MW-1:0]    n_m_res, n_m_orig;

    assign n_m_res  = MW'(cfg.mix);
    assign n_m_orig = ONE_M - n_m_res;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s5_po   <= r_s4_base[cfg.tgt_idx] * n_m_orig;
            r_s5_pr   <= r_s4_r * n_m_res;
            r_s5_base <= r_s4_base;
        end
    end

    // stage 6: round, saturate, clamp, write target
    logic signed [PB-1:0] r_s6_out [4];
    logic signed [SW-1:0] n_mixed, n_final;

    always_comb begin
        n_mixed = sat_s((WD'(r_s5_po) + WD'(r_s5_pr) + RND12) >>> 12);
        n_final = n_mixed;
        if (cfg.clamp) begin
            if (n_mixed < 0) begin
                n_final = '0;
            end else if (n_mixed > ONE_S) begin
                n_final = ONE_S;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int i = 0; i < 4; i++) begin
                r_s6_out[i] <= (cfg.tgt_en && (2'(i) == cfg.tgt_idx)) ? n_final[PB-1:0]
                                                                     : r_s5_base[i];
            end
        end
    end

    assign o_out_red   = r_s6_out[0];
    assign o_out_green = r_s6_out[1];
    assign o_out_blue  = r_s6_out[2];
    assign o_out_alpha = r_s6_out[3];

    `CBM_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    `CBM_ASSERT_HOLD(a_stall_only_full, i_clk, i_rst_n, o_stall, (&r_vld) && i_stall)
    `CBM_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule

// ----- src/cbm_regs.sv -----
module cbm_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [cbm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [cbm_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output cbm_pkg::t_cfg                  o_cfg
);

    logic [2:0]  r_a_ch;
    logic [2:0]  r_b_ch;
    logic [2:0]  r_op;
    logic [1:0]  r_tgt;
    logic [12:0] r_mix;
    logic        r_clamp;
    logic [2:0]  r_a_cnt;
    logic [2:0]  r_b_cnt;

    logic             wr_en;
    cbm_pkg::t_reg_idx idx;
    logic [2:0]       na;
    logic [2:0]       nb;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = cbm_pkg::t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ch  <= cbm_pkg::RST_A_CHANNEL;
            r_b_ch  <= cbm_pkg::RST_B_CHANNEL;
            r_op    <= cbm_pkg::RST_BLEND_OP;
            r_tgt   <= cbm_pkg::RST_TARGET;
            r_mix   <= cbm_pkg::RST_MIX;
            r_clamp <= cbm_pkg::RST_CLAMP;
            r_a_cnt <= cbm_pkg::RST_A_COUNT;
            r_b_cnt <= cbm_pkg::RST_B_COUNT;
        end else if (wr_en) begin
            case (idx)
                cbm_pkg::REG_A_CHANNEL: r_a_ch  <= pwdata[2:0];
                cbm_pkg::REG_B_CHANNEL: r_b_ch  <= pwdata[2:0];
                cbm_pkg::REG_BLEND_OP:  r_op    <= pwdata[2:0];
                cbm_pkg::REG_TARGET:    r_tgt   <= pwdata[1:0];
                cbm_pkg::REG_MIX:       r_mix   <= pwdata[12:0];
                cbm_pkg::REG_CLAMP:     r_clamp <= pwdata[0];
                cbm_pkg::REG_A_COUNT:   r_a_cnt <= pwdata[2:0];
                cbm_pkg::REG_B_COUNT:   r_b_cnt <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cbm_pkg::REG_A_CHANNEL: prdata = cbm_pkg::DATA_BITS'(r_a_ch);
            cbm_pkg::REG_B_CHANNEL: prdata = cbm_pkg::DATA_BITS'(r_b_ch);
            cbm_pkg::REG_BLEND_OP:  prdata = cbm_pkg::DATA_BITS'(r_op);
            cbm_pkg::REG_TARGET:    prdata = cbm_pkg::DATA_BITS'(r_tgt);
            cbm_pkg::REG_MIX:       prdata = cbm_pkg::DATA_BITS'(r_mix);
            cbm_pkg::REG_CLAMP:     prdata = cbm_pkg::DATA_BITS'(r_clamp);
            cbm_pkg::REG_A_COUNT:   prdata = cbm_pkg::DATA_BITS'(r_a_cnt);
            cbm_pkg::REG_B_COUNT:   prdata = cbm_pkg::DATA_BITS'(r_b_cnt);
            default:                prdata = '0;
        endcase
    end

    // normalize counts to 1..4, selects above luminance to luminance
    always_comb begin
        na = (r_a_cnt == 3'd0) ? 3'd1 :
             (r_a_cnt > cbm_pkg::MAX_COUNT) ? cbm_pkg::MAX_COUNT : r_a_cnt;
        nb = (r_b_cnt == 3'd0) ? 3'd1 :
             (r_b_cnt > cbm_pkg::MAX_COUNT) ? cbm_pkg::MAX_COUNT : r_b_cnt;

        o_cfg.a_ch = (r_a_ch > 3'(cbm_pkg::CH_LUMA)) ? cbm_pkg::CH_LUMA
                                                    : cbm_pkg::t_chan'(r_a_ch);
        o_cfg.b_ch = (r_b_ch > 3'(cbm_pkg::CH_LUMA)) ? cbm_pkg::CH_LUMA
                                                    : cbm_pkg::t_chan'(r_b_ch);
        o_cfg.op    = cbm_pkg::t_op'(r_op);
        o_cfg.mix   = (r_mix > cbm_pkg::ONE_Q12) ? cbm_pkg::ONE_Q12 : r_mix;
        o_cfg.clamp = r_clamp;
        o_cfg.a_cnt = na;
        o_cfg.b_cnt = nb;

        if (nb == 3'd1) begin
            o_cfg.tgt_en  = (r_tgt == 2'(cbm_pkg::TGT_ALPHA));
            o_cfg.tgt_idx = 2'(cbm_pkg::TGT_RED);
        end else begin
            o_cfg.tgt_en  = (3'(r_tgt) < nb);
            o_cfg.tgt_idx = r_tgt;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT         = 4096;
    localparam longint HALF_UNIT    = 2048;
    localparam int     HOLD_CYCLES  = 64;
    localparam int     DRAIN_SETTLE = 10;
    localparam int     PHASE_ITEMS  = 80;
    localparam int     PHASES       = 8;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_pixel;

    typedef struct packed {
        t_pixel a;
        logic   a_inside;
        t_pixel b;
        logic   b_inside;
    } t_pixel_pair;

    typedef struct packed {
        logic [2:0]    a_sel;
        logic [2:0]    b_sel;
        cbm_pkg::t_op  op;
        cbm_pkg::t_tgt target;
        logic [12:0]   mix;
        logic          clamp;
        logic [2:0]    a_cnt;
        logic [2:0]    b_cnt;
    } t_merge_cfg;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [15:0]            i_a_red, i_a_green, i_a_blue, i_a_alpha;
    logic                          i_a_inside;
    logic signed [15:0]            i_b_red, i_b_green, i_b_blue, i_b_alpha;
    logic                          i_b_inside;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [15:0]            o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic                          psel, penable, pwrite;
    logic [cbm_pkg::ADDR_BITS-1:0] paddr;
    logic [cbm_pkg::DATA_BITS-1:0] pwdata;
    logic [cbm_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;

    t_pixel     expected_pixels[$];
    t_merge_cfg live_cfg;
    bit         steady_flow  = 1'b0;
    bit         hold_request = 1'b0;
    int         error_count      = 0;
    int         pixels_sent      = 0;
    int         results_checked  = 0;
    int         settings_applied = 0;

    channel_blend_merge_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_a_red    (i_a_red),
        .i_a_green  (i_a_green),
        .i_a_blue   (i_a_blue),
        .i_a_alpha  (i_a_alpha),
        .i_a_inside (i_a_inside),
        .i_b_red    (i_b_red),
        .i_b_green  (i_b_green),
        .i_b_blue   (i_b_blue),
        .i_b_alpha  (i_b_alpha),
        .i_b_inside (i_b_inside),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_red  (o_out_red),
        .o_out_green(o_out_green),
        .o_out_blue (o_out_blue),
        .o_out_alpha(o_out_alpha),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- merge predictor ----------------

    function automatic longint saturate(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint q12_product(input longint x, input longint y);
        return floor_div(x * y + HALF_UNIT, UNIT);
    endfunction

    function automatic int effective_count(input logic [2:0] c);
        if (c == 3'd0) return 1;
        if (c > cbm_pkg::MAX_COUNT) return int'(cbm_pkg::MAX_COUNT);
        return int'(c);
    endfunction

    function automatic longint channel_sample(input t_pixel px, input logic present,
                                              input int n, input logic [2:0] sel);
        longint r, g, b, al;
        r  = $signed(px.red);
        g  = $signed(px.green);
        b  = $signed(px.blue);
        al = $signed(px.alpha);
        if (!present) return 0;
        if (n == 1) return r;
        case (sel)
            cbm_pkg::CH_RED:   return r;
            cbm_pkg::CH_GREEN: return g;
            cbm_pkg::CH_BLUE:  return (n > 2) ? b : 0;
            cbm_pkg::CH_ALPHA: return (n > 3) ? al : UNIT;
            default: begin
                if (n <= 2) b = r;
                return saturate(floor_div(cbm_pkg::LUMA_R * r + cbm_pkg::LUMA_G * g
                                          + cbm_pkg::LUMA_B * b + HALF_UNIT, UNIT));
            end
        endcase
    endfunction

    function automatic longint blend_samples(input longint a, input longint b,
                                             input cbm_pkg::t_op op);
        case (op)
            cbm_pkg::OP_COPY:     return a;
            cbm_pkg::OP_PLUS:     return saturate(b + a);
            cbm_pkg::OP_MULTIPLY: return saturate(q12_product(b, a));
            cbm_pkg::OP_SCREEN:   return saturate(UNIT - q12_product(UNIT - b, UNIT - a));
            cbm_pkg::OP_MAX:      return (b > a) ? b : a;
            cbm_pkg::OP_MIN:      return (b < a) ? b : a;
            cbm_pkg::OP_SUBTRACT: return saturate(b - a);
            default: begin
                if (b <= HALF_UNIT)
                    return saturate(floor_div(a * b + 1024, 2048));
                return saturate(UNIT - floor_div((UNIT - a) * (UNIT - b) + 1024, 2048));
            end
        endcase
    endfunction

    function automatic t_pixel predict_merge(input t_pixel_pair px, input t_merge_cfg c);
        longint base[4];
        longint bpx[4];
        longint m, sa, sb, r;
        int     na, nb, tgt;
        t_pixel res;
        bpx[0] = $signed(px.b.red);
        bpx[1] = $signed(px.b.green);
        bpx[2] = $signed(px.b.blue);
        bpx[3] = $signed(px.b.alpha);
        na = effective_count(c.a_cnt);
        nb = effective_count(c.b_cnt);
        for (int i = 0; i < 4; i++)
            base[i] = (px.b_inside && i < nb) ? bpx[i] : 0;
        tgt = -1;
        if (nb == 1) begin
            if (c.target == cbm_pkg::TGT_ALPHA) tgt = 0;
        end else if (int'(c.target) < nb) begin
            tgt = int'(c.target);
        end
        m = c.mix;
        if (m > UNIT) m = UNIT;
        if (tgt >= 0) begin
            sa = channel_sample(px.a, px.a_inside, na, c.a_sel);
            sb = channel_sample(px.b, px.b_inside, nb, c.b_sel);
            r  = blend_samples(sa, sb, c.op);
            r  = saturate(floor_div(base[tgt] * (UNIT - m) + r * m + HALF_UNIT, UNIT));
            if (c.clamp) begin
                if (r < 0) r = 0;
                if (r > UNIT) r = UNIT;
            end
            base[tgt] = r;
        end
        res.red   = base[0][15:0];
        res.green = base[1][15:0];
        res.blue  = base[2][15:0];
        res.alpha = base[3][15:0];
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_merge_cfg default_cfg();
        t_merge_cfg c;
        c.a_sel  = cbm_pkg::RST_A_CHANNEL;
        c.b_sel  = cbm_pkg::RST_B_CHANNEL;
        c.op     = cbm_pkg::t_op'(cbm_pkg::RST_BLEND_OP);
        c.target = cbm_pkg::t_tgt'(cbm_pkg::RST_TARGET);
        c.mix    = cbm_pkg::RST_MIX;
        c.clamp  = cbm_pkg::RST_CLAMP;
        c.a_cnt  = cbm_pkg::RST_A_COUNT;
        c.b_cnt  = cbm_pkg::RST_B_COUNT;
        return c;
    endfunction

    function automatic t_pixel_pair make_pair(
        input logic [15:0] ar, ag, ab, aa, input logic ai,
        input logic [15:0] br, bg, bb, ba, input logic bi);
        t_pixel_pair p;
        p.a = '{red: ar, green: ag, blue: ab, alpha: aa};
        p.a_inside = ai;
        p.b = '{red: br, green: bg, blue: bb, alpha: ba};
        p.b_inside = bi;
        return p;
    endfunction

    function automatic logic [15:0] random_component();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom());
            4, 5, 6, 7: return 16'($urandom_range(10240) - 2048);
            8:          return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default:    return 16'($urandom_range(2) * 2048);
        endcase
    endfunction

    function automatic t_pixel_pair random_pair();
        return make_pair(random_component(), random_component(), random_component(),
                         random_component(), $urandom_range(99) < 85,
                         random_component(), random_component(), random_component(),
                         random_component(), $urandom_range(99) < 85);
    endfunction

    function automatic logic [2:0] random_select();
        if ($urandom_range(9) == 0) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(4));
    endfunction

    function automatic logic [2:0] random_count();
        if ($urandom_range(7) == 0) return 3'($urandom_range(5, 8));
        return 3'($urandom_range(1, 4));
    endfunction

    function automatic t_merge_cfg random_cfg();
        t_merge_cfg c;
        c.a_sel  = random_select();
        c.b_sel  = random_select();
        c.op     = cbm_pkg::t_op'($urandom_range(7));
        c.target = cbm_pkg::t_tgt'($urandom_range(3));
        case ($urandom_range(5))
            0:       c.mix = 13'd0;
            1:       c.mix = cbm_pkg::ONE_Q12;
            2:       c.mix = 13'($urandom_range(4097, 8191));
            default: c.mix = 13'($urandom_range(4096));
        endcase
        c.clamp = 1'($urandom_range(1));
        c.a_cnt = random_count();
        c.b_cnt = random_count();
        return c;
    endfunction

    task automatic write_register(input cbm_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cbm_pkg::REG_A_CHANNEL: live_cfg.a_sel  = value[2:0];
            cbm_pkg::REG_B_CHANNEL: live_cfg.b_sel  = value[2:0];
            cbm_pkg::REG_BLEND_OP:  live_cfg.op     = cbm_pkg::t_op'(value[2:0]);
            cbm_pkg::REG_TARGET:    live_cfg.target = cbm_pkg::t_tgt'(value[1:0]);
            cbm_pkg::REG_MIX:       live_cfg.mix    = value[12:0];
            cbm_pkg::REG_CLAMP:     live_cfg.clamp  = value[0];
            cbm_pkg::REG_A_COUNT:   live_cfg.a_cnt  = value[2:0];
            default:                live_cfg.b_cnt  = value[2:0];
        endcase
    endtask

    task automatic apply_config(input t_merge_cfg c);
        write_register(cbm_pkg::REG_A_CHANNEL, 32'(c.a_sel));
        write_register(cbm_pkg::REG_B_CHANNEL, 32'(c.b_sel));
        write_register(cbm_pkg::REG_BLEND_OP,  32'(c.op));
        write_register(cbm_pkg::REG_TARGET,    32'(c.target));
        write_register(cbm_pkg::REG_MIX,       32'(c.mix));
        write_register(cbm_pkg::REG_CLAMP,     32'(c.clamp));
        write_register(cbm_pkg::REG_A_COUNT,   32'(c.a_cnt));
        write_register(cbm_pkg::REG_B_COUNT,   32'(c.b_cnt));
        settings_applied++;
    endtask

    task automatic send_pixel(input t_pixel_pair px);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_a_red    <= px.a.red;
        i_a_green  <= px.a.green;
        i_a_blue   <= px.a.blue;
        i_a_alpha  <= px.a.alpha;
        i_a_inside <= px.a_inside;
        i_b_red    <= px.b.red;
        i_b_green  <= px.b.green;
        i_b_blue   <= px.b.blue;
        i_b_alpha  <= px.b.alpha;
        i_b_inside <= px.b_inside;
        do @(posedge i_clk); while (o_stall);
        expected_pixels = {expected_pixels, predict_merge(px, live_cfg)};
        pixels_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SETTLE) @(negedge i_clk);
    endtask

    task automatic run_case(input t_merge_cfg c, input t_pixel_pair px);
        apply_config(c);
        send_pixel(px);
        drain_results();
    endtask

    // ---------------- tests ----------------

    task automatic test_field_extremes();
        send_pixel(make_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
                             16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        send_pixel(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
                             16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
        send_pixel(make_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
                             16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
        send_pixel(make_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
                             16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        send_pixel(make_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1,
                             16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1));
        send_pixel(make_pair(16'h1234, 16'h0800, 16'h2000, 16'h3000, 1'b0,
                             16'hF000, 16'h0400, 16'h0C00, 16'h8000, 1'b1));
        send_pixel(make_pair(16'h1234, 16'h0800, 16'h2000, 16'h3000, 1'b1,
                             16'hF000, 16'h0400, 16'h0C00, 16'h8000, 1'b0));
        send_pixel(make_pair(16'h1234, 16'h0800, 16'h2000, 16'h3000, 1'b0,
                             16'hF000, 16'h0400, 16'h0C00, 16'h8000, 1'b0));
        drain_results();
    endtask

    task automatic test_blend_operations();
        t_merge_cfg c;
        c        = default_cfg();
        c.a_sel  = cbm_pkg::CH_RED;
        c.b_sel  = cbm_pkg::CH_GREEN;
        c.target = cbm_pkg::TGT_BLUE;
        for (int k = cbm_pkg::OP_COPY; k <= cbm_pkg::OP_OVERLAY; k++) begin
            c.op = cbm_pkg::t_op'(k);
            apply_config(c);
            send_pixel(make_pair(16'hFB2E, 16'h0100, 16'h0200, 16'h0300, 1'b1,
                                 16'h0111, 16'h0C00, 16'h0222, 16'h0333, 1'b1));
            drain_results();
        end
        send_pixel(make_pair(16'h0C00, 16'h0, 16'h0, 16'h0, 1'b1,
                             16'h0, 16'h0800, 16'h0, 16'h0, 1'b1));
        send_pixel(make_pair(16'h0C00, 16'h0, 16'h0, 16'h0, 1'b1,
                             16'h0, 16'h0801, 16'h0, 16'h0, 1'b1));
        drain_results();
        c.op = cbm_pkg::OP_PLUS;
        run_case(c, make_pair(16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b1,
                              16'h0, 16'h7FFF, 16'h0, 16'h0, 1'b1));
    endtask

    task automatic test_special_cases();
        t_merge_cfg c;
        // clamp to the unit range, half mix
        c        = default_cfg();
        c.a_sel  = cbm_pkg::CH_RED;
        c.b_sel  = cbm_pkg::CH_GREEN;
        c.op     = cbm_pkg::OP_PLUS;
        c.target = cbm_pkg::TGT_GREEN;
        c.mix    = 13'd2048;
        c.clamp  = 1'b1;
        run_case(c, make_pair(16'h4000, 16'h0, 16'h0, 16'h0, 1'b1,
                              16'h0, 16'h4000, 16'h0, 16'h0, 1'b1));
        run_case(c, make_pair(16'h8000, 16'h0, 16'h0, 16'h0, 1'b1,
                              16'h0, 16'hF000, 16'h0, 16'h0, 1'b1));
        // register values outside their legal ranges
        c        = default_cfg();
        c.a_sel  = 3'd7;
        c.b_sel  = 3'd5;
        c.op     = cbm_pkg::OP_SUBTRACT;
        c.target = cbm_pkg::TGT_RED;
        c.mix    = 13'h1FFF;
        c.a_cnt  = 3'd0;
        c.b_cnt  = 3'd7;
        run_case(c, make_pair(16'h0900, 16'h0700, 16'h0500, 16'h0300, 1'b1,
                              16'h1000, 16'h2000, 16'h0400, 16'h0100, 1'b1));
        c.a_cnt  = 3'd5;
        c.b_cnt  = 3'd0;
        c.target = cbm_pkg::TGT_ALPHA;
        run_case(c, make_pair(16'h0900, 16'h0700, 16'h0500, 16'h0300, 1'b1,
                              16'h1000, 16'h2000, 16'h0400, 16'h0100, 1'b1));
        // single component on both sides
        c        = default_cfg();
        c.a_sel  = cbm_pkg::CH_GREEN;
        c.b_sel  = cbm_pkg::CH_BLUE;
        c.op     = cbm_pkg::OP_PLUS;
        c.a_cnt  = 3'd1;
        c.b_cnt  = 3'd1;
        run_case(c, make_pair(16'h0400, 16'h0800, 16'h0C00, 16'h1000, 1'b1,
                              16'h0200, 16'h0600, 16'h0A00, 16'h0E00, 1'b1));
        c.target = cbm_pkg::TGT_RED;
        run_case(c, make_pair(16'h0400, 16'h0800, 16'h0C00, 16'h1000, 1'b1,
                              16'h0200, 16'h0600, 16'h0A00, 16'h0E00, 1'b1));
        // missing channels read as zero or one, luminance falls back to red
        c        = default_cfg();
        c.a_sel  = cbm_pkg::CH_ALPHA;
        c.b_sel  = cbm_pkg::CH_LUMA;
        c.op     = cbm_pkg::OP_MULTIPLY;
        c.target = cbm_pkg::TGT_BLUE;
        c.a_cnt  = 3'd2;
        c.b_cnt  = 3'd3;
        run_case(c, make_pair(16'h0400, 16'h0800, 16'h0C00, 16'h1000, 1'b1,
                              16'h0600, 16'h0A00, 16'h0E00, 16'h0300, 1'b1));
        c.a_sel  = cbm_pkg::CH_LUMA;
        c.b_sel  = cbm_pkg::CH_BLUE;
        c.op     = cbm_pkg::OP_PLUS;
        c.target = cbm_pkg::TGT_GREEN;
        c.b_cnt  = 3'd2;
        run_case(c, make_pair(16'h0400, 16'h0800, 16'h7000, 16'h1000, 1'b1,
                              16'h0600, 16'h0A00, 16'h0E00, 16'h0300, 1'b1));
        // target beyond the component count passes the base through
        c.target = cbm_pkg::TGT_BLUE;
        run_case(c, make_pair(16'h0400, 16'h0800, 16'h7000, 16'h1000, 1'b1,
                              16'h0600, 16'h0A00, 16'h0E00, 16'h0300, 1'b1));
        c.target = cbm_pkg::TGT_ALPHA;
        c.b_cnt  = 3'd3;
        run_case(c, make_pair(16'h0400, 16'h0800, 16'h7000, 16'h1000, 1'b1,
                              16'h0600, 16'h0A00, 16'h0E00, 16'h0300, 1'b1));
    endtask

    task automatic test_output_backpressure();
        apply_config(random_cfg());
        fork
            begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            repeat (40) send_pixel(random_pair());
        join
        drain_results();
    endtask

    task automatic test_random_traffic();
        t_merge_cfg c;
        for (int ph = 0; ph < PHASES; ph++) begin
            c = random_cfg();
            if (ph == 0) begin
                c.mix   = 13'd0;
                c.clamp = 1'b1;
            end
            if (ph == 1) c.mix = 13'h1FFF;
            apply_config(c);
            steady_flow = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(random_pair());
                if (n == PHASE_ITEMS / 2) drain_results();
            end
            drain_results();
            steady_flow = 1'b0;
        end
    endtask

    // ---------------- output side ----------------

    initial begin : output_stall_gen
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= !steady_flow && ($urandom_range(99) < 8);
            end
        end
    end

    task automatic compare_component(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0d ns: %s mismatch, expected %0d actual %0d",
                     $time, name, $signed(want), $signed(got));
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0d ns: extra output, expected none, actual %0d %0d %0d %0d",
                         $time, o_out_red, o_out_green, o_out_blue, o_out_alpha);
            end else begin
                want = expected_pixels.pop_front();
                compare_component("red",   want.red,   o_out_red);
                compare_component("green", want.green, o_out_green);
                compare_component("blue",  want.blue,  o_out_blue);
                compare_component("alpha", want.alpha, o_out_alpha);
                results_checked++;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_a_red    = '0;
        i_a_green  = '0;
        i_a_blue   = '0;
        i_a_alpha  = '0;
        i_a_inside = 1'b0;
        i_b_red    = '0;
        i_b_green  = '0;
        i_b_blue   = '0;
        i_b_alpha  = '0;
        i_b_inside = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        live_cfg   = default_cfg();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_blend_operations();
        test_special_cases();
        test_output_backpressure();
        test_random_traffic();

        drain_results();
        $display("Checked %0d merged pixels of %0d sent under %0d register settings",
                 results_checked, pixels_sent, settings_applied);
        $display("Covered every blend operation, channel and count, clamping and backpressure");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
